@@ sv/mlpt_pkg.sv @@
// shared constants, codes and types of the multi-level page table
`default_nettype none

package mlpt_pkg;

  localparam int ADDRESS_BITS_DEF   = 32;
  localparam int MAX_LEVEL_BITS_DEF = 8;
  localparam int NODE_SLOTS_DEF     = 64;
  localparam int FRAME_BITS_DEF     = 20;

  localparam int MAX_LEVELS = 4;
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int LC_W       = 3;
  localparam int LB_W       = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int CNT_W      = 32;
  localparam int STATUS_W   = 3;

  localparam logic [LC_W-1:0] LC_RESET = 3'd1;
  localparam logic [LB_W-1:0] LB_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BITS_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BITS_3  = 3'd4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_ALREADY    = 3'd1,
    ST_HIT        = 3'd2,
    ST_MISS       = 3'd3,
    ST_POOL_FULL  = 3'd4,
    ST_BAD_CONFIG = 3'd5
  } status_t;

  typedef struct packed {
    logic too_wide;
    logic too_long;
  } idx_flags_t;

endpackage

`default_nettype wire

@@ sv/mlpt_ram.sv @@
// entry store: one write port, one registered read port
`default_nettype none

module mlpt_ram #(
  parameter int AW = 14,
  parameter int DW = 21
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/mlpt_idx_unit.sv @@
// shared per-level unit: bit total accumulate, limit checks and index extraction
`default_nettype none

module mlpt_idx_unit #(
  parameter int ADDRESS_BITS   = 32,
  parameter int MAX_LEVEL_BITS = 8,
  parameter int TOT_W          = 6
) (
  input  logic [ADDRESS_BITS-1:0]   addr,
  input  logic [mlpt_pkg::LB_W-1:0] bits,
  input  logic [TOT_W-1:0]          total_in,
  output logic [MAX_LEVEL_BITS-1:0] idx,
  output logic [TOT_W-1:0]          total_out,
  output mlpt_pkg::idx_flags_t      flags
);
  import mlpt_pkg::*;

  localparam int WIDE_W = ADDRESS_BITS + MAX_LEVEL_BITS;

  logic [TOT_W-1:0]          shift_amt;
  logic [WIDE_W-1:0]         shifted;
  logic [MAX_LEVEL_BITS-1:0] mask;

  always_comb begin
    total_out      = total_in + TOT_W'(bits);
    flags.too_long = total_out >= TOT_W'(ADDRESS_BITS);
    flags.too_wide = 32'(bits) > 32'(MAX_LEVEL_BITS);
    shift_amt      = TOT_W'(ADDRESS_BITS) - total_out;
    shifted        = {{MAX_LEVEL_BITS{1'b0}}, addr} >> shift_amt;
    mask           = ~({MAX_LEVEL_BITS{1'b1}} << bits);
    idx            = shifted[MAX_LEVEL_BITS-1:0] & mask;
  end

endmodule

`default_nettype wire

@@ sv/multi_level_page_table.sv @@
// radix page table top level: sequencer, configuration, counters and result register
// steps: each transaction makes level_count index steps through the shared index
// unit, then a read and an evaluate step per level walked, plus one write per new
// node and one for its leaf; result strobe one cycle
// throughput: one transaction at a time, start is taken only while busy is low
// reset and every register write run a clearing pass over all 2**(log2(NODE_SLOTS) +
// MAX_LEVEL_BITS) entries (16384 by default) with busy high; the receiver cannot stall
`default_nettype none

module multi_level_page_table #(
  parameter int ADDRESS_BITS   = mlpt_pkg::ADDRESS_BITS_DEF,
  parameter int MAX_LEVEL_BITS = mlpt_pkg::MAX_LEVEL_BITS_DEF,
  parameter int NODE_SLOTS     = mlpt_pkg::NODE_SLOTS_DEF,
  parameter int FRAME_BITS     = mlpt_pkg::FRAME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_func,
  input  logic [ADDRESS_BITS-1:0]          in_logical_address,
  input  logic [FRAME_BITS-1:0]            in_frame_in,
  output logic                             out_valid,
  output logic [mlpt_pkg::STATUS_W-1:0]    out_status,
  output logic [FRAME_BITS-1:0]            out_frame_out,
  output logic [mlpt_pkg::CNT_W-1:0]       out_hit_count,
  output logic [mlpt_pkg::CNT_W-1:0]       out_mapped_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mlpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlpt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mlpt_pkg::*;

  localparam int NODE_W = $clog2(NODE_SLOTS);
  localparam int NF_W   = $clog2(NODE_SLOTS + 1);
  localparam int AW     = NODE_W + MAX_LEVEL_BITS;
  localparam int DATA_W = (FRAME_BITS > NF_W) ? FRAME_BITS : NF_W;
  localparam int DW     = DATA_W + 1;
  localparam int TOT_W  = $clog2(ADDRESS_BITS + 16);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CHECK = 6'b000100,
    S_READ  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_ALLOC = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [LVL_W-1:0]          lvl_r, lvl_nxt;
  logic [NODE_W-1:0]         node_r, node_nxt;
  logic [NF_W-1:0]           next_free_r, next_free_nxt;
  logic [TOT_W-1:0]          total_r, total_nxt;
  logic [AW-1:0]             clr_r, clr_nxt;
  logic [CNT_W-1:0]          hit_r, hit_nxt;
  logic [CNT_W-1:0]          mapped_r, mapped_nxt;
  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [FRAME_BITS-1:0]     out_frame_r, out_frame_nxt;

  logic                      func_r;
  logic [ADDRESS_BITS-1:0]   addr_r;
  logic [FRAME_BITS-1:0]     frame_r;
  logic [MAX_LEVEL_BITS-1:0] idx_r [MAX_LEVELS];
  logic [LC_W-1:0]           lc_r;
  logic [LB_W-1:0]           lbits_r [MAX_LEVELS];

  logic [MAX_LEVEL_BITS-1:0] iu_idx;
  logic [TOT_W-1:0]          iu_total;
  idx_flags_t                iu_flags;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [DW-1:0]             ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [DW-1:0]             ram_rdata;

  logic [AW-1:0]             cur_slot;
  logic                      leaf;
  logic [LC_W-1:0]           needed;
  logic                      rd_valid;
  logic [DATA_W-1:0]         rd_data;
  logic                      rd_child_ok;
  logic                      pool_short;
  logic                      lc_bad;
  logic                      cfg_take;
  logic                      cfg_clear;
  logic [CFG_IDX_W-1:0]      cfg_lvl;

  mlpt_idx_unit #(
    .ADDRESS_BITS  (ADDRESS_BITS),
    .MAX_LEVEL_BITS(MAX_LEVEL_BITS),
    .TOT_W         (TOT_W)
  ) u_idx_unit (
    .addr     (addr_r),
    .bits     (lbits_r[lvl_r]),
    .total_in (total_r),
    .idx      (iu_idx),
    .total_out(iu_total),
    .flags    (iu_flags)
  );

  mlpt_ram #(
    .AW(AW),
    .DW(DW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = ((state_r == S_IDLE) && !start) || (state_r == S_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_frame_out    = out_frame_r;
  assign out_hit_count    = hit_r;
  assign out_mapped_count = mapped_r;

  assign cfg_take  = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_take && (cfg_index <= REG_LEVEL_BITS_3);
  assign cfg_lvl   = cfg_index - REG_LEVEL_BITS_0;

  always_comb begin
    cur_slot    = {node_r, idx_r[lvl_r]};
    leaf        = (LC_W'(lvl_r) == (lc_r - LC_W'(1)));
    needed      = lc_r - LC_W'(1) - LC_W'(lvl_r);
    rd_valid    = ram_rdata[DW-1];
    rd_data     = ram_rdata[DATA_W-1:0];
    rd_child_ok = 32'(rd_data) < 32'(NODE_SLOTS);
    pool_short  = (32'(needed) + 32'(next_free_r)) > 32'(NODE_SLOTS);
    lc_bad      = (lc_r == '0) || (32'(lc_r) > 32'(MAX_LEVELS));

    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    node_nxt       = node_r;
    next_free_nxt  = next_free_r;
    total_nxt      = total_r;
    clr_nxt        = clr_r;
    hit_nxt        = hit_r;
    mapped_nxt     = mapped_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_slot;
    ram_wdata      = '0;
    ram_raddr      = cur_slot;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          lvl_nxt   = '0;
          total_nxt = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (lc_bad || iu_flags.too_wide || iu_flags.too_long) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BAD_CONFIG;
          out_frame_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          total_nxt = iu_total;
          if (leaf) begin
            lvl_nxt   = '0;
            node_nxt  = '0;
            state_nxt = S_READ;
          end else begin
            lvl_nxt = lvl_r + LVL_W'(1);
          end
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (func_r == FUNC_LOOKUP) begin
          if (!rd_valid || (!leaf && !rd_child_ok)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            out_frame_nxt  = '0;
            state_nxt      = S_IDLE;
          end else if (leaf) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_HIT;
            out_frame_nxt  = rd_data[FRAME_BITS-1:0];
            state_nxt      = S_IDLE;
          end else begin
            node_nxt  = rd_data[NODE_W-1:0];
            lvl_nxt   = lvl_r + LVL_W'(1);
            state_nxt = S_READ;
          end
        end else if (leaf) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (rd_valid) begin
            hit_nxt        = hit_r + CNT_W'(1);
            out_status_nxt = ST_ALREADY;
            out_frame_nxt  = rd_data[FRAME_BITS-1:0];
          end else begin
            ram_we         = 1'b1;
            ram_wdata      = {1'b1, DATA_W'(frame_r)};
            mapped_nxt     = mapped_r + CNT_W'(1);
            out_status_nxt = ST_INSERTED;
            out_frame_nxt  = frame_r;
          end
        end else if (rd_valid && rd_child_ok) begin
          node_nxt  = rd_data[NODE_W-1:0];
          lvl_nxt   = lvl_r + LVL_W'(1);
          state_nxt = S_READ;
        end else if (pool_short) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_POOL_FULL;
          out_frame_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        ram_we = 1'b1;
        if (leaf) begin
          ram_wdata      = {1'b1, DATA_W'(frame_r)};
          mapped_nxt     = mapped_r + CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_INSERTED;
          out_frame_nxt  = frame_r;
          state_nxt      = S_IDLE;
        end else begin
          ram_wdata     = {1'b1, DATA_W'(next_free_r)};
          node_nxt      = next_free_r[NODE_W-1:0];
          next_free_nxt = next_free_r + NF_W'(1);
          lvl_nxt       = lvl_r + LVL_W'(1);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    // register write restarts the clearing pass
    if (cfg_clear) begin
      state_nxt     = S_CLEAR;
      clr_nxt       = '0;
      next_free_nxt = NF_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      lvl_r        <= '0;
      node_r       <= '0;
      next_free_r  <= NF_W'(1);
      total_r      <= '0;
      clr_r        <= '0;
      hit_r        <= '0;
      mapped_r     <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_INSERTED;
    end else begin
      state_r      <= state_nxt;
      lvl_r        <= lvl_nxt;
      node_r       <= node_nxt;
      next_free_r  <= next_free_nxt;
      total_r      <= total_nxt;
      clr_r        <= clr_nxt;
      hit_r        <= hit_nxt;
      mapped_r     <= mapped_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_frame_r <= out_frame_nxt;
    if (state_r == S_IDLE && start) begin
      func_r  <= in_func;
      addr_r  <= in_logical_address;
      frame_r <= in_frame_in;
    end
    if (state_r == S_CHECK) begin
      idx_r[lvl_r] <= iu_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r <= LC_RESET;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        lbits_r[i] <= LB_RESET;
      end
    end else if (cfg_take) begin
      if (cfg_index == REG_LEVEL_COUNT) begin
        lc_r <= cfg_data[LC_W-1:0];
      end else if (cfg_index <= REG_LEVEL_BITS_3) begin
        lbits_r[cfg_lvl[LVL_W-1:0]] <= cfg_data[LB_W-1:0];
      end
    end
  end

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_clear) |=> busy)
    else $error("accepted transaction did not make the block busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without a transaction in progress");

  a_pool_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r != '0) && (32'(next_free_r) <= 32'(NODE_SLOTS)))
    else $error("node allocation pointer out of range");

  a_mapped_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_INSERTED) |->
      (out_mapped_count == $past(out_mapped_count) + CNT_W'(1)))
    else $error("insert reported without a mapping count step");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_MISS || out_status == ST_POOL_FULL ||
                   out_status == ST_BAD_CONFIG)) |-> (out_frame_out == '0))
    else $error("nonzero frame on miss or error");

endmodule

`default_nettype wire
